// File: rtl/bsfb_pkg.sv
// Shared constants, types and codes for the BMP stream framebuffer blitter.
`timescale 1ns / 1ps
package bsfb_pkg;

    // Largest accepted image width or height.
    localparam int MAX_DIM = 8192;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);

    // Fixed field widths.
    localparam int FBW_W   = 14;
    localparam int POS_W   = 13;
    localparam int IMG_W   = 14;
    localparam int BPP_W   = 16;
    localparam int PB_W    = BPP_W - 4;   // bytes per pixel from a positive 16-bit bpp
    localparam int ADDR_W  = 32;
    localparam int ROW_W   = ((DIM_W > POS_W) ? DIM_W : POS_W) + 1;
    localparam int XD_W    = ((FBW_W > DIM_W) ? FBW_W : DIM_W) + 1;
    localparam int MUL_W   = ROW_W + FBW_W;

    // Header layout.
    localparam int HDR_LEN   = 54;
    localparam int OFS_PDO   = 10;
    localparam int OFS_WIDTH = 18;
    localparam int OFS_HGT   = 22;
    localparam int OFS_BPP   = 28;
    localparam int FB_BYTES  = 4;
    localparam int MIN_PB    = 3;

    // Parse phases.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_PIXELS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FB_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_PLACE_X     = 2'd1;
    localparam logic [1:0] CFG_PLACE_Y     = 2'd2;
    localparam logic [1:0] CFG_CENTER_MODE = 2'd3;

    localparam logic [FBW_W-1:0] FB_WIDTH_RST = FBW_W'(1024);

    typedef struct packed {
        logic [FBW_W-1:0] fb_width;
        logic [POS_W-1:0] place_x;
        logic [POS_W-1:0] place_y;
        logic             center_mode;
    } bsfb_cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_offset;
        logic [7:0]        byte_value;
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
        logic              last_write;
        logic              format_error;
    } bsfb_result_t;

    typedef struct packed {
        logic [1:0] phase;
    } bsfb_status_t;

endpackage

// File: rtl/bmp_stream_framebuffer_blitter_top.sv
// Top level of the BMP byte stream to framebuffer blitter.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                                         Handshake
//  s_*       in         tdata: file_byte; tuser: first_byte             tvalid/tready
//  m_*       out        tdata: byte_offset, byte_value, image_width,    tvalid/tready
//                       image_height; tlast: last_write;
//                       tuser: format_error
//  cfg_*     in         cfg_index 0..3, cfg_wdata                       cfg_wr_en, no wait
//
//  One file byte per cycle, sustained while m_tready does not stall the result
//  register. A byte is held in the input register and its write, if any, is
//  loaded into the result register when the byte fires, raising m_tvalid. The
//  row multiply (row * fb_width) feeds the parser's row base register and sets
//  the clock.
//  Reset (aresetn low, synchronous) empties both registers and restarts the
//  parse at file position zero. A stall on m_tready holds the result and the
//  pending byte; s_tready stays high while the input register is empty.
//
module bmp_stream_framebuffer_blitter_top
    import bsfb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] file_byte
    input  logic             s_tuser,    // [0] first_byte

    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,    // [31:0] byte_offset, [39:32] byte_value,
                                         // [53:40] image_width, [67:54] image_height,
                                         // [71:68] zero
    output logic             m_tlast,    // last_write
    output logic             m_tuser,    // [0] format_error

    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [FBW_W-1:0] cfg_wdata
);

    bsfb_cfg_t    cfg;
    bsfb_result_t res;
    bsfb_result_t res_out;
    bsfb_status_t status;
    logic         res_valid;
    logic         out_free;
    logic         fire;

    // Input register: one file byte waiting for the parser.
    logic         in_vld_reg, in_vld_next;
    logic [7:0]   in_byte_reg;
    logic         in_first_reg;
    logic         s_accept;

    assign s_accept    = s_tvalid && s_tready;
    // Advance the parser only when the result register can take its output.
    assign fire        = in_vld_reg && out_free;
    assign s_tready    = !in_vld_reg || out_free;
    assign in_vld_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    bsfb_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg)
    );

    bsfb_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .fire       (fire),
        .file_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .res_valid  (res_valid),
        .res        (res),
        .status     (status)
    );

    bsfb_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .res        (res),
        .free       (out_free),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res_out    (res_out)
    );

    // Pack the result item, first field in the lowest bits.
    assign m_tdata = {4'b0000, res_out.image_height, res_out.image_width,
                      res_out.byte_value, res_out.byte_offset};
    assign m_tlast = res_out.last_write;
    assign m_tuser = res_out.format_error;

    // A format error carries no write and never ends an image.
    a_err_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[39:0] == 40'd0 && !m_tlast))
        else $error("format error result carries write data");

    // A pending byte is held while the result register is blocked.
    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && m_tvalid && !m_tready) |=> in_vld_reg)
        else $error("pending byte lost during output stall");

    // Once done, the parse only leaves that phase for a new header.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.phase == PH_DONE) |=> (status.phase == PH_DONE || status.phase == PH_HEADER))
        else $error("parser left done phase without restart");

    // No result is produced unless a byte was processed.
    a_res_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> fire)
        else $error("result produced without a processed byte");

endmodule

// File: rtl/bsfb_cfg_regs.sv
// Configuration register bank for the blitter.
`timescale 1ns / 1ps
module bsfb_cfg_regs
    import bsfb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [FBW_W-1:0] cfg_wdata,
    output bsfb_cfg_t        cfg
);

    bsfb_cfg_t cfg_reg;
    bsfb_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FB_WIDTH:    cfg_next.fb_width    = cfg_wdata;
                CFG_PLACE_X:     cfg_next.place_x     = cfg_wdata[POS_W-1:0];
                CFG_PLACE_Y:     cfg_next.place_y     = cfg_wdata[POS_W-1:0];
                CFG_CENTER_MODE: cfg_next.center_mode = cfg_wdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fb_width    <= FB_WIDTH_RST;
            cfg_reg.place_x     <= '0;
            cfg_reg.place_y     <= '0;
            cfg_reg.center_mode <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/bsfb_parser.sv
// Header parser and pixel address generator: one file byte per fire.
`timescale 1ns / 1ps
module bsfb_parser
    import bsfb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  bsfb_cfg_t    cfg,
    input  logic         fire,
    input  logic [7:0]   file_byte,
    input  logic         first_byte,
    output logic         res_valid,
    output bsfb_result_t res,
    output bsfb_status_t status
);

    logic [31:0]       pos_reg, pos_next;
    logic [31:0]       pdo_reg, pdo_next;
    logic [31:0]       hw_reg, hw_next;
    logic [31:0]       hh_reg, hh_next;
    logic [BPP_W-1:0]  bpp_reg, bpp_next;
    logic [DIM_W-1:0]  srow_reg, srow_next;
    logic [DIM_W-1:0]  scol_reg, scol_next;
    logic [PB_W-1:0]   bip_reg, bip_next;
    logic [PB_W-1:0]   pb_reg, pb_next;
    logic [1:0]        phase_reg, phase_next;
    logic [31:0]       rbase_reg, rbase_next;

    // Row base for either the first row (header end) or the next row.
    logic                    hdr_end;
    logic [DIM_W-1:0]        srow_inc;
    logic [DIM_W-1:0]        scol_inc;
    logic [DIM_W-1:0]        row_sel;
    logic [ROW_W-1:0]        fb_row;
    logic [MUL_W-1:0]        row_prod;
    logic signed [XD_W-1:0]  xd;
    logic signed [XD_W-1:0]  xd_adj;
    logic signed [XD_W-1:0]  xd_half;
    logic [31:0]             x_start;
    logic [31:0]             row_base_calc;

    // the first row is set up only from the header phase
    assign hdr_end  = (phase_reg == PH_HEADER);
    assign srow_inc = srow_reg + DIM_W'(1);
    assign scol_inc = scol_reg + DIM_W'(1);
    assign row_sel  = hdr_end ? '0 : srow_inc;

    always_comb begin
        fb_row   = ROW_W'(cfg.place_y) + ROW_W'(hh_reg[DIM_W-1:0]) - ROW_W'(row_sel);
        row_prod = MUL_W'(fb_row) * MUL_W'(cfg.fb_width);
        xd       = XD_W'(cfg.fb_width) - XD_W'(hw_reg[DIM_W-1:0]);
        // halve toward zero
        xd_adj   = xd[XD_W-1] ? (xd + XD_W'(1)) : xd;
        xd_half  = xd_adj >>> 1;
        x_start  = cfg.center_mode ? 32'(xd_half) : 32'(cfg.place_x);
        row_base_calc = (x_start + 32'(row_prod)) << 2;
    end

    always_comb begin
        logic [31:0]       p;
        logic [1:0]        lane;
        logic              hdr_ok;
        logic              do_pixel;
        logic [PB_W-1:0]   bip_inc;

        p        = first_byte ? '0 : pos_reg;
        lane     = '0;
        hdr_ok   = 1'b0;
        do_pixel = 1'b0;
        bip_inc  = bip_reg + PB_W'(1);

        pos_next   = pos_reg;
        pdo_next   = pdo_reg;
        hw_next    = hw_reg;
        hh_next    = hh_reg;
        bpp_next   = bpp_reg;
        srow_next  = srow_reg;
        scol_next  = scol_reg;
        bip_next   = bip_reg;
        pb_next    = pb_reg;
        phase_next = phase_reg;
        rbase_next = rbase_reg;

        res_valid        = 1'b0;
        res.byte_offset  = rbase_reg + 32'({scol_reg, 2'b00}) + 32'(bip_reg[1:0]);
        res.byte_value   = file_byte;
        res.image_width  = hw_reg[IMG_W-1:0];
        res.image_height = hh_reg[IMG_W-1:0];
        res.last_write   = (bip_reg == PB_W'(2)) && (scol_inc == hw_reg[DIM_W-1:0])
                           && (srow_inc == hh_reg[DIM_W-1:0]);
        res.format_error = 1'b0;

        // restart the parse on a new file
        if (first_byte) begin
            pdo_next   = '0;
            hw_next    = '0;
            hh_next    = '0;
            bpp_next   = '0;
            srow_next  = '0;
            scol_next  = '0;
            bip_next   = '0;
            rbase_next = '0;
            phase_next = PH_HEADER;
        end

        case (first_byte ? PH_HEADER : phase_reg)
            PH_HEADER: begin
                if (p >= 32'(OFS_PDO) && p < 32'(OFS_PDO + 4)) begin
                    lane = 2'(p - 32'(OFS_PDO));
                    pdo_next[{lane, 3'b000} +: 8] = file_byte;
                end else if (p >= 32'(OFS_WIDTH) && p < 32'(OFS_WIDTH + 4)) begin
                    lane = 2'(p - 32'(OFS_WIDTH));
                    hw_next[{lane, 3'b000} +: 8] = file_byte;
                end else if (p >= 32'(OFS_HGT) && p < 32'(OFS_HGT + 4)) begin
                    lane = 2'(p - 32'(OFS_HGT));
                    hh_next[{lane, 3'b000} +: 8] = file_byte;
                end else if (p >= 32'(OFS_BPP) && p < 32'(OFS_BPP + 2)) begin
                    lane = 2'(p - 32'(OFS_BPP));
                    bpp_next[lane[0]*8 +: 8] = file_byte;
                end
                if (p == 32'(HDR_LEN - 1)) begin
                    hdr_ok = !bpp_reg[BPP_W-1] && (bpp_reg[BPP_W-2:3] >= PB_W'(MIN_PB))
                             && !hw_reg[31] && (hw_reg != '0) && (hw_reg <= 32'(MAX_DIM))
                             && !hh_reg[31] && (hh_reg != '0) && (hh_reg <= 32'(MAX_DIM));
                    if (hdr_ok) begin
                        if ($signed(pdo_reg) < $signed(32'(HDR_LEN))) begin
                            pdo_next = 32'(HDR_LEN);
                        end
                        pb_next    = bpp_reg[BPP_W-2:3];
                        srow_next  = '0;
                        scol_next  = '0;
                        bip_next   = '0;
                        rbase_next = row_base_calc;
                        phase_next = PH_SKIP;
                    end else begin
                        res_valid        = 1'b1;
                        res.byte_offset  = '0;
                        res.byte_value   = '0;
                        res.last_write   = 1'b0;
                        res.format_error = 1'b1;
                        phase_next       = PH_DONE;
                    end
                end
            end
            PH_SKIP: begin
                if (p == pdo_reg) begin
                    phase_next = PH_PIXELS;
                    do_pixel   = 1'b1;
                end
            end
            PH_PIXELS: do_pixel = 1'b1;
            default:   do_pixel = 1'b0;
        endcase

        if (do_pixel) begin
            // only the first three bytes of a pixel reach the framebuffer
            res_valid = (bip_reg < PB_W'(MIN_PB));
            bip_next  = bip_inc;
            if (bip_inc >= pb_reg) begin
                bip_next  = '0;
                scol_next = scol_inc;
                if (32'(scol_inc) >= hw_reg) begin
                    scol_next = '0;
                    srow_next = srow_inc;
                    if (32'(srow_inc) >= hh_reg) begin
                        phase_next = PH_DONE;
                    end else begin
                        rbase_next = row_base_calc;
                    end
                end
            end
        end

        pos_next = p + 32'(1);
        if (!fire) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            pdo_reg   <= '0;
            hw_reg    <= '0;
            hh_reg    <= '0;
            bpp_reg   <= '0;
            srow_reg  <= '0;
            scol_reg  <= '0;
            bip_reg   <= '0;
            pb_reg    <= PB_W'(MIN_PB);
            phase_reg <= PH_HEADER;
            rbase_reg <= '0;
        end else if (fire) begin
            pos_reg   <= pos_next;
            pdo_reg   <= pdo_next;
            hw_reg    <= hw_next;
            hh_reg    <= hh_next;
            bpp_reg   <= bpp_next;
            srow_reg  <= srow_next;
            scol_reg  <= scol_next;
            bip_reg   <= bip_next;
            pb_reg    <= pb_next;
            phase_reg <= phase_next;
            rbase_reg <= rbase_next;
        end
    end

    assign status.phase = phase_reg;

endmodule

// File: rtl/bsfb_out_reg.sv
// Result register in front of the master-side stream.
`timescale 1ns / 1ps
module bsfb_out_reg
    import bsfb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  bsfb_result_t res,
    output logic         free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output bsfb_result_t res_out
);

    logic         vld_reg, vld_next;
    bsfb_result_t res_reg;

    assign free     = !vld_reg || m_tready;
    assign vld_next = load ? 1'b1 : (m_tready ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = vld_reg;
    assign res_out  = res_reg;

endmodule
